// ----- rtl/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and codes of the ticket priority table.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Operation codes, carried on the slave-side tuser.
  typedef enum logic [1:0] {
    OP_REGISTER  = 2'd0,
    OP_SET_LEVEL = 2'd1,
    OP_PROCESS   = 2'd2,
    OP_SEARCH    = 2'd3
  } op_e;

  // Result status, carried on the master-side tuser.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Priority levels.
  localparam logic [1:0] LVL_LOW    = 2'd0;
  localparam logic [1:0] LVL_MEDIUM = 2'd1;
  localparam logic [1:0] LVL_HIGH   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  // One table slot as stored in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [1:0]  level;
    logic [31:0] arr_time;
    logic [31:0] seq;
  } slot_t;

  localparam int unsigned SlotBits = $bits(slot_t);

endpackage

// ----- rtl/tpt_ram.sv -----
// ----------------------------------------------------------------------------
// tpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ticket_priority_table.sv -----
// ----------------------------------------------------------------------------
// ticket_priority_table
// Table of pending tickets with register, set-priority, search and process.
// ----------------------------------------------------------------------------
// All slots live in one synchronous RAM of ENTRIES words (valid, key, level,
// timestamp, registration number). After reset the block runs a clearing pass
// that writes every slot invalid; tready stays low meanwhile. Each operation
// is a full scan of the RAM, one slot per cycle through the single read port,
// followed by a write-back state. One item is in work at a time; a new item
// is accepted while the previous result still waits in the output register.
// Register takes the lowest free slot at low priority, or reports full. Set
// priority and search act on the oldest registration of a key. Process
// removes the slot of highest level, smallest timestamp on a tie, oldest
// registration on a further tie. Any non-ok status comes with zero key,
// level and time.
module ticket_priority_table
  import tpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // ticket_key[31:0], new_level[33:32],
                                      // arrival_time[65:34], zero fill
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // found_key[31:0], found_level[33:32],
                                      // found_time[65:34], zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = AW + 1;

  // Control state
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pend_q, pend_d;
  logic           found_q, found_d;
  logic [31:0]    next_order_q, next_order_d;
  logic           m_tvalid_q, m_tvalid_d;

  // Payload
  op_e            op_q, op_d;
  logic [31:0]    key_q, key_d;
  logic [1:0]     lvl_q, lvl_d;
  logic [31:0]    tim_q, tim_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [AW-1:0]  best_idx_q, best_idx_d;
  slot_t          best_q, best_d;
  logic [31:0]    best_age_q, best_age_d;
  status_e        res_status_q, res_status_d;
  logic [65:0]    res_data_q, res_data_d;
  logic [1:0]     m_user_q, m_user_d;
  logic [65:0]    m_data_q, m_data_d;

  // Slot memory ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  slot_t          ram_wdata;
  logic           ram_re;
  slot_t          ram_rdata;
  logic [SlotBits-1:0] ram_rbits;

  // Scan evaluation
  logic [31:0]    cur_age;
  logic           take;
  logic           scan_end;

  tpt_ram #(
    .WIDTH (SlotBits),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = slot_t'(ram_rbits);
  assign scan_end  = (cnt_q == CW'(ENTRIES));
  assign cur_age   = next_order_q - ram_rdata.seq;

  // Decide whether the slot read last cycle becomes the new candidate.
  always_comb begin
    take = 1'b0;
    case (op_q)
      OP_REGISTER: begin
        take = !ram_rdata.valid && !found_q;
      end
      OP_SET_LEVEL, OP_SEARCH: begin
        take = ram_rdata.valid && (ram_rdata.key == key_q) &&
               (!found_q || (cur_age > best_age_q));
      end
      OP_PROCESS: begin
        take = ram_rdata.valid &&
               (!found_q || (ram_rdata.level > best_q.level) ||
                ((ram_rdata.level == best_q.level) &&
                 ((ram_rdata.arr_time < best_q.arr_time) ||
                  ((ram_rdata.arr_time == best_q.arr_time) &&
                   (cur_age > best_age_q)))));
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    found_d      = found_q;
    next_order_d = next_order_q;
    op_d         = op_q;
    key_d        = key_q;
    lvl_d        = lvl_q;
    tim_d        = tim_q;
    idx_d        = idx_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    best_age_d   = best_age_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    m_user_d     = m_user_q;
    m_data_d     = m_data_q;
    m_tvalid_d   = m_tvalid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      S_CLEAR: begin
        // Sweep the slot memory, writing every entry invalid.
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        cnt_d     = cnt_q + CW'(1);
        if (cnt_q == CW'(ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          key_d   = s_axis_tdata[31:0];
          // Saturate the unused level code to high.
          lvl_d   = (s_axis_tdata[33:32] > LVL_HIGH) ? LVL_HIGH : s_axis_tdata[33:32];
          tim_d   = s_axis_tdata[65:34];
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; evaluate each word once the registered read returns it.
        if (!scan_end) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = cnt_q[AW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (pend_q && take) begin
          found_d    = 1'b1;
          best_idx_d = idx_q;
          best_d     = ram_rdata;
          best_age_d = cur_age;
        end
        if (scan_end && !pend_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        res_status_d = STAT_OK;
        res_data_d   = '0;
        case (op_q)
          OP_REGISTER: begin
            if (found_q) begin
              ram_we             = 1'b1;
              ram_wdata.valid    = 1'b1;
              ram_wdata.key      = key_q;
              ram_wdata.level    = LVL_LOW;
              ram_wdata.arr_time = tim_q;
              ram_wdata.seq      = next_order_q;
              next_order_d       = next_order_q + 32'd1;
              res_data_d         = {tim_q, LVL_LOW, key_q};
            end else begin
              res_status_d = STAT_FULL;
            end
          end
          OP_SET_LEVEL: begin
            if (found_q) begin
              ram_we          = 1'b1;
              ram_wdata       = best_q;
              ram_wdata.level = lvl_q;
              res_data_d      = {best_q.arr_time, lvl_q, best_q.key};
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          OP_SEARCH: begin
            if (found_q) begin
              res_data_d = {best_q.arr_time, best_q.level, best_q.key};
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          OP_PROCESS: begin
            if (found_q) begin
              ram_we          = 1'b1;
              ram_wdata       = best_q;
              ram_wdata.valid = 1'b0;
              res_data_d      = {best_q.arr_time, best_q.level, best_q.key};
            end else begin
              res_status_d = STAT_EMPTY;
            end
          end
          default: begin
            res_status_d = STAT_NOT_FOUND;
          end
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_user_d   = res_status_q;
          m_data_d   = res_data_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      next_order_q <= '0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      next_order_q <= next_order_d;
      m_tvalid_q   <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    lvl_q        <= lvl_d;
    tim_q        <= tim_d;
    idx_q        <= idx_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    best_age_q   <= best_age_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    m_user_q     <= m_user_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = {6'd0, m_data_q};

  // An accepted transfer always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_SCAN)
    else $error("accepted transfer did not start a scan");

  // Memory writes never overlap a scan in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WRITE || state_q == S_CLEAR))
    else $error("slot write outside write-back or clearing");

  // A failed operation reports zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
    else $error("non-ok result with nonzero fields");

  // The registration counter only steps by one, on a successful register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(next_order_q) |->
      (next_order_q == $past(next_order_q) + 32'd1) && ($past(state_q) == S_WRITE))
    else $error("registration counter moved unexpectedly");

  // The output register is only reloaded from the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result presented without completing an operation");

endmodule

// ----- sim/tb_ticket_priority_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ticket_priority_table
// Self-checking bench for the ticket priority table. A scoreboard keeps its
// own copy of the slot table and works out the reply to every accepted
// request: register, set priority, search and process. Each reply from the
// block is compared with it field by field. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_ticket_priority_table
  import tpt_pkg::*;
;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 1300;

  // Request mixes used in the random part.
  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  typedef struct {
    status_e     status;
    logic [31:0] key;
    logic [1:0]  level;
    logic [31:0] stamp;
  } ticket_reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow slot table plus the replies still owed by the block.
  // --------------------------------------------------------------------------
  class ticket_table_sb;
    bit            live     [DEPTH];
    logic [31:0]   key_of   [DEPTH];
    logic [1:0]    level_of [DEPTH];
    logic [31:0]   stamp_of [DEPTH];
    logic [31:0]   seq_of   [DEPTH];
    logic [31:0]   next_seq;
    ticket_reply_t pending_replies[$];
    int unsigned   failures;

    function void clear();
      foreach (live[i]) live[i] = 1'b0;
      next_seq = '0;
      pending_replies.delete();
      failures = 0;
    endfunction

    // Registrations since the slot was filled, modulo 2^32.
    function logic [31:0] age(int s);
      return next_seq - seq_of[s];
    endfunction

    function int oldest_with_key(logic [31:0] k);
      int best;
      best = -1;
      for (int s = 0; s < DEPTH; s++) begin
        if (live[s] && key_of[s] == k && (best < 0 || age(s) > age(best))) best = s;
      end
      return best;
    endfunction

    // Highest level, then smallest timestamp, then oldest registration.
    function int next_to_process();
      int best;
      best = -1;
      for (int s = 0; s < DEPTH; s++) begin
        if (!live[s]) continue;
        if (best < 0 || level_of[s] > level_of[best]) begin
          best = s;
        end else if (level_of[s] == level_of[best]) begin
          if (stamp_of[s] < stamp_of[best] ||
              (stamp_of[s] == stamp_of[best] && age(s) > age(best))) best = s;
        end
      end
      return best;
    endfunction

    function void note_request(op_e op, logic [31:0] k, logic [1:0] lvl,
                               logic [31:0] stamp);
      ticket_reply_t r;
      int            s;
      logic [1:0]    sat;
      r.status = STAT_OK;
      r.key    = '0;
      r.level  = '0;
      r.stamp  = '0;
      sat = (lvl > LVL_HIGH) ? LVL_HIGH : lvl;
      s = -1;
      case (op)
        OP_REGISTER: begin
          for (int i = DEPTH - 1; i >= 0; i--) if (!live[i]) s = i;
          if (s < 0) begin
            r.status = STAT_FULL;
          end else begin
            live[s]     = 1'b1;
            key_of[s]   = k;
            level_of[s] = LVL_LOW;
            stamp_of[s] = stamp;
            seq_of[s]   = next_seq;
            next_seq    = next_seq + 32'd1;
          end
        end
        OP_SET_LEVEL, OP_SEARCH: begin
          s = oldest_with_key(k);
          if (s < 0) r.status = STAT_NOT_FOUND;
          else if (op == OP_SET_LEVEL) level_of[s] = sat;
        end
        default: begin
          s = next_to_process();
          if (s < 0) r.status = STAT_EMPTY;
        end
      endcase
      if (r.status == STAT_OK) begin
        r.key   = key_of[s];
        r.level = level_of[s];
        r.stamp = stamp_of[s];
        if (op == OP_PROCESS) live[s] = 1'b0;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(ticket_reply_t got);
      ticket_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request waiting: status %0d key %h", got.status, got.key);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.key !== want.key) begin
        $error("found_key: expected %h, got %h", want.key, got.key);
        failures++;
      end
      if (got.level !== want.level) begin
        $error("found_level: expected %0d, got %0d", want.level, got.level);
        failures++;
      end
      if (got.stamp !== want.stamp) begin
        $error("found_time: expected %h, got %h", want.stamp, got.stamp);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // ticket_key[31:0], new_level[33:32],
                               // arrival_time[65:34], zero fill
  logic [1:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // found_key[31:0], found_level[33:32],
                               // found_time[65:34], zero fill
  logic [1:0]  m_axis_tuser;   // status

  ticket_priority_table #(
    .ENTRIES(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ticket_table_sb sb;
  logic [31:0]    key_pool [16];
  bit             calm;          // set during the stretch with no stalls

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Roughly 17 in a hundred calls ask for a stall, except during the calm stretch.
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  // Mostly keys from a small pool, so duplicates and search hits are common.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 65) return key_pool[$urandom_range(15)];
    return $urandom();
  endfunction

  // Small stamps force ties on the timestamp; extremes now and then.
  function automatic logic [31:0] pick_stamp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(15);
    if (roll < 45) return 32'h0000_0000;
    if (roll < 50) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Present one request and hold it until the block takes it. Called at a
  // rising edge; returns at the edge of the transfer with tvalid still high.
  task automatic send_request(input op_e op, input logic [31:0] k,
                              input logic [1:0] lvl, input logic [31:0] stamp);
    int gap;
    gap = 0;
    // Mostly short gaps; now and then one longer than a whole scan.
    if (idle_now()) gap = ($urandom_range(9) == 0) ? $urandom_range(4, 90)
                                                    : $urandom_range(1, 3);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, stamp, lvl, k};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, k, lvl, stamp);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every transfer, then pick tready for the next cycle.
  // --------------------------------------------------------------------------
  initial begin
    ticket_reply_t got;
    int            hold_left;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.key    = m_axis_tdata[31:0];
        got.level  = m_axis_tdata[33:32];
        got.stamp  = m_axis_tdata[65:34];
        sb.check_reply(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_now()) begin
        // Occasionally hold a reply, at times long enough for the next scan to finish.
        hold_left = ($urandom_range(9) == 0) ? $urandom_range(4, 80) : 0;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    op_mix_e mix;
    int      mix_left;
    int      roll;
    op_e     op;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_REGISTER;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    sb = new();
    sb.clear();

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'hA5A5_A5A5;
    key_pool[3] = 32'h5A5A_5A5A;
    for (int i = 4; i < 16; i++) key_pool[i] = $urandom();

    // Hold reset, then release it; the block then clears its slots on its own
    // with tready low, which the first transfer simply waits out.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extreme keys and stamps, duplicates, level
    // saturation, unknown key, and every tie-break of process.
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_SEARCH,    32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_SET_LEVEL, 32'h0000_0000, LVL_HIGH, 32'h0000_0000);
    send_request(OP_REGISTER,  32'h0000_0000, LVL_LOW,  32'hFFFF_FFFF);
    send_request(OP_REGISTER,  32'hFFFF_FFFF, LVL_LOW,  32'h0000_0000);
    send_request(OP_REGISTER,  32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_SEARCH,    32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_SET_LEVEL, 32'h0000_0000, 2'd3,     32'h0000_0000);
    send_request(OP_SET_LEVEL, 32'hFFFF_FFFF, LVL_MEDIUM, 32'h0000_0000);
    send_request(OP_SEARCH,    32'h0000_0001, LVL_LOW,  32'h0000_0000);
    send_request(OP_REGISTER,  32'h0000_0005, LVL_LOW,  32'h0000_0007);
    send_request(OP_REGISTER,  32'h0000_0006, LVL_LOW,  32'h0000_0007);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_SEARCH,    32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_REGISTER,  32'h0000_0009, LVL_LOW,  32'h0000_0003);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);
    send_request(OP_PROCESS,   32'h0000_0000, LVL_LOW,  32'h0000_0000);

    // Random: episodes of different request mixes. Open with a long fill so
    // the table overflows early; drain episodes take it back to empty.
    mix = MIX_FILL;
    mix_left = 130;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mix_left == 0) begin
        mix = op_mix_e'($urandom_range(2));
        mix_left = $urandom_range(40, 120);
      end
      mix_left--;
      calm = (n >= 500 && n < 750);
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL:  op = (roll < 70) ? OP_REGISTER : (roll < 80) ? OP_PROCESS :
                        (roll < 90) ? OP_SET_LEVEL : OP_SEARCH;
        MIX_DRAIN: op = (roll < 65) ? OP_PROCESS : (roll < 75) ? OP_REGISTER :
                        (roll < 87) ? OP_SET_LEVEL : OP_SEARCH;
        default:   op = op_e'(roll % 4);
      endcase
      send_request(op, pick_key(), 2'($urandom_range(3)), pick_stamp());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain the replies still owed, then allow one more scan for strays.
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
